### src/baro_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric compensation package
// Field widths, coefficient register indexes and pipeline constants.
// ----------------------------------------------------------------------------
package baro_pkg;

    // Field widths
    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int PRESS_W   = 32;
    localparam int TEMP_W    = 19;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 48;  // raw_pressure + raw_temperature
    localparam int OUT_DATA_W = 56;  // pressure_pa + temp_centideg, padded to bytes

    // Coefficient register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENS     = 3'd0;  // C1
    localparam logic [CFG_IDX_W-1:0] REG_OFF      = 3'd1;  // C2
    localparam logic [CFG_IDX_W-1:0] REG_TCS      = 3'd2;  // C3
    localparam logic [CFG_IDX_W-1:0] REG_TCO      = 3'd3;  // C4
    localparam logic [CFG_IDX_W-1:0] REG_TREF     = 3'd4;  // C5
    localparam logic [CFG_IDX_W-1:0] REG_TEMPSENS = 3'd5;  // C6

    // Temperature thresholds, hundredths of a degree
    localparam logic signed [19:0] TEMP_REF = 20'sd2000;
    localparam logic signed [19:0] TEMP_LOW = -20'sd1500;

    // Output temperature limits
    localparam logic signed [19:0] TEMP_MAX = 20'sd262143;
    localparam logic signed [19:0] TEMP_MIN = -20'sd262144;

    // Pipeline depth, input register to output register
    localparam int NUM_STAGES = 9;

endpackage

### src/baro_pressure_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric pressure compensation, second order
// Raw 24-bit D1/D2 conversions in, compensated pressure (Pa) and temperature
// (0.01 C) out, using six calibration coefficients C1..C6.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   s_axis_tvalid/tready    raw_pressure, raw_temperature
//  m_axis    out  m_axis_tvalid/tready    pressure_pa, temp_centideg
//  cfg       in   cfg_we (no ready)       cfg_index, cfg_data (C1..C6)
//
//  One request per clock while m_axis does not stall; the stages below carry the
//  multipliers (dT products, squares, D1*SENS split into two partial products).
//  rst_n clears the valid bits and the coefficients to zero.
//  A stall on m_axis holds the whole pipeline (single global enable); no
//  request is lost or repeated, and s_axis_tready drops only while the output
//  register is full and not being taken.
//
// Stage map:
//   1  dT = D2 - C5*256
//   2  dT*C6, C4*dT, C3*dT, dT*dT
//   3  TEMP, OFF, SENS first order, T2
//   4  (TEMP-2000)^2, (TEMP+1500)^2, threshold flags
//   5  OFF2, SENS2, corrected TEMP
//   6  corrected OFF, SENS, TEMP clamp
//   7  D1*SENS partial products (low 20 bits / high 21 bits of SENS)
//   8  partial product sum
//   9  (D1*SENS/2^21 - OFF)/2^15 -> output register
// ----------------------------------------------------------------------------
module baro_pressure_compensation_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [baro_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [baro_pkg::COEF_W-1:0]         cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [baro_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [23:0] raw_pressure,
                                                                // [47:24] raw_temperature
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [baro_pkg::OUT_DATA_W-1:0]     m_axis_tdata    // [31:0] pressure_pa,
                                                                // [50:32] temp_centideg, rest 0
);
    import baro_pkg::*;

    // ------------------------------------------------------------------
    // Coefficients
    // ------------------------------------------------------------------
    logic [COEF_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SENS:     c1_reg <= cfg_data;
                REG_OFF:      c2_reg <= cfg_data;
                REG_TCS:      c3_reg <= cfg_data;
                REG_TCO:      c4_reg <= cfg_data;
                REG_TREF:     c5_reg <= cfg_data;
                REG_TEMPSENS: c6_reg <= cfg_data;
                default:      ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: whole pipeline advances when the output slot is free
    // or being taken.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  adv;

    assign adv           = !vld_reg[NUM_STAGES-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_axis_tvalid};
    end

    // ------------------------------------------------------------------
    // Stage 1: temperature delta
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]   raw_p;
    logic [RAW_W-1:0]   raw_t;
    logic signed [24:0] dt_next;
    logic signed [24:0] dt_s1_reg;
    logic [RAW_W-1:0]   d1_s1_reg;

    assign raw_p   = s_axis_tdata[RAW_W-1:0];
    assign raw_t   = s_axis_tdata[2*RAW_W-1:RAW_W];
    assign dt_next = $signed({1'b0, raw_t}) - $signed({1'b0, c5_reg, 8'b0});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dt_s1_reg <= dt_next;
            d1_s1_reg <= raw_p;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dT products
    // ------------------------------------------------------------------
    logic signed [41:0] pt_next, poff_next, psens_next;
    logic signed [49:0] pdd_next;
    logic signed [41:0] pt_s2_reg, poff_s2_reg, psens_s2_reg;
    logic signed [49:0] pdd_s2_reg;
    logic [RAW_W-1:0]   d1_s2_reg;

    assign pt_next    = dt_s1_reg * $signed({1'b0, c6_reg});
    assign poff_next  = dt_s1_reg * $signed({1'b0, c4_reg});
    assign psens_next = dt_s1_reg * $signed({1'b0, c3_reg});
    assign pdd_next   = dt_s1_reg * dt_s1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_s2_reg    <= pt_next;
            poff_s2_reg  <= poff_next;
            psens_s2_reg <= psens_next;
            pdd_s2_reg   <= pdd_next;
            d1_s2_reg    <= d1_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: first-order TEMP, OFF, SENS and T2
    // ------------------------------------------------------------------
    logic signed [19:0] temp1_next;
    logic signed [36:0] off1_next;
    logic signed [35:0] sens1_next;
    logic [17:0]        t2_next;
    logic signed [19:0] temp1_s3_reg;
    logic signed [36:0] off1_s3_reg;
    logic signed [35:0] sens1_s3_reg;
    logic [17:0]        t2_s3_reg;
    logic [RAW_W-1:0]   d1_s3_reg;

    assign temp1_next = $signed({pt_s2_reg[41], pt_s2_reg[41:23]}) + TEMP_REF;
    assign off1_next  = $signed({5'b0, c2_reg, 16'b0})
                      + $signed({{2{poff_s2_reg[41]}}, poff_s2_reg[41:7]});
    assign sens1_next = $signed({5'b0, c1_reg, 15'b0})
                      + $signed({{2{psens_s2_reg[41]}}, psens_s2_reg[41:8]});
    // dT^2 is non-negative and below 2^49
    assign t2_next    = pdd_s2_reg[48:31];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            temp1_s3_reg <= temp1_next;
            off1_s3_reg  <= off1_next;
            sens1_s3_reg <= sens1_next;
            t2_s3_reg    <= t2_next;
            d1_s3_reg    <= d1_s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squares for the second-order terms
    // ------------------------------------------------------------------
    logic signed [20:0] da;
    logic signed [20:0] db;
    logic signed [41:0] sqa_full;
    logic signed [41:0] sqb_full;
    logic               lt_ref_next, lt_low_next;
    logic [35:0]        sqa_s4_reg, sqb_s4_reg;
    logic               lt_ref_s4_reg, lt_low_s4_reg;
    logic signed [19:0] temp1_s4_reg;
    logic signed [36:0] off1_s4_reg;
    logic signed [35:0] sens1_s4_reg;
    logic [17:0]        t2_s4_reg;
    logic [RAW_W-1:0]   d1_s4_reg;

    assign da          = {temp1_s3_reg[19], temp1_s3_reg} - {TEMP_REF[19], TEMP_REF};
    assign db          = {temp1_s3_reg[19], temp1_s3_reg} - {TEMP_LOW[19], TEMP_LOW};
    assign sqa_full    = da * da;
    assign sqb_full    = db * db;
    assign lt_ref_next = temp1_s3_reg < TEMP_REF;
    assign lt_low_next = temp1_s3_reg < TEMP_LOW;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqa_s4_reg    <= sqa_full[35:0];
            sqb_s4_reg    <= sqb_full[35:0];
            lt_ref_s4_reg <= lt_ref_next;
            lt_low_s4_reg <= lt_low_next;
            temp1_s4_reg  <= temp1_s3_reg;
            off1_s4_reg   <= off1_s3_reg;
            sens1_s4_reg  <= sens1_s3_reg;
            t2_s4_reg     <= t2_s3_reg;
            d1_s4_reg     <= d1_s3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: OFF2, SENS2, corrected temperature
    // ------------------------------------------------------------------
    logic [39:0]        sqa_x5;
    logic [39:0]        sqb_x7;
    logic [39:0]        sqb_x11;
    logic [39:0]        off2_next;
    logic [39:0]        sens2_next;
    logic signed [19:0] temp2_next;
    logic [39:0]        off2_s5_reg, sens2_s5_reg;
    logic signed [19:0] temp2_s5_reg;
    logic               lt_ref_s5_reg;
    logic signed [36:0] off1_s5_reg;
    logic signed [35:0] sens1_s5_reg;
    logic [RAW_W-1:0]   d1_s5_reg;

    assign sqa_x5  = {4'b0, sqa_s4_reg} + {2'b0, sqa_s4_reg, 2'b0};
    assign sqb_x7  = {1'b0, sqb_s4_reg, 3'b0} - {4'b0, sqb_s4_reg};
    assign sqb_x11 = {1'b0, sqb_s4_reg, 3'b0} + {3'b0, sqb_s4_reg, 1'b0}
                   + {4'b0, sqb_s4_reg};

    always_comb
    begin
        off2_next  = {1'b0, sqa_x5[39:1]};
        sens2_next = {2'b0, sqa_x5[39:2]};
        if (lt_low_s4_reg)
        begin
            off2_next  = off2_next + sqb_x7;
            sens2_next = sens2_next + {1'b0, sqb_x11[39:1]};
        end
        if (lt_ref_s4_reg)
            temp2_next = temp1_s4_reg - $signed({2'b0, t2_s4_reg});
        else
            temp2_next = temp1_s4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            off2_s5_reg   <= off2_next;
            sens2_s5_reg  <= sens2_next;
            temp2_s5_reg  <= temp2_next;
            lt_ref_s5_reg <= lt_ref_s4_reg;
            off1_s5_reg   <= off1_s4_reg;
            sens1_s5_reg  <= sens1_s4_reg;
            d1_s5_reg     <= d1_s4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: corrected OFF and SENS, temperature clamp
    // ------------------------------------------------------------------
    logic signed [40:0]       off_next;
    logic signed [40:0]       sens_next;
    logic signed [TEMP_W-1:0] temp_next;
    logic signed [40:0]       off_s6_reg, sens_s6_reg;
    logic signed [TEMP_W-1:0] temp_s6_reg;
    logic [RAW_W-1:0]         d1_s6_reg;

    always_comb
    begin
        off_next  = {{4{off1_s5_reg[36]}}, off1_s5_reg};
        sens_next = {{5{sens1_s5_reg[35]}}, sens1_s5_reg};
        if (lt_ref_s5_reg)
        begin
            off_next  = off_next - $signed({1'b0, off2_s5_reg});
            sens_next = sens_next - $signed({1'b0, sens2_s5_reg});
        end
        priority if (temp2_s5_reg > TEMP_MAX)
            temp_next = TEMP_MAX[TEMP_W-1:0];
        else if (temp2_s5_reg < TEMP_MIN)
            temp_next = TEMP_MIN[TEMP_W-1:0];
        else
            temp_next = temp2_s5_reg[TEMP_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            off_s6_reg  <= off_next;
            sens_s6_reg <= sens_next;
            temp_s6_reg <= temp_next;
            d1_s6_reg   <= d1_s5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: D1*SENS as two partial products
    // ------------------------------------------------------------------
    logic [43:0]              pp_lo_next;
    logic signed [45:0]       pp_hi_next;
    logic [43:0]              pp_lo_s7_reg;
    logic signed [45:0]       pp_hi_s7_reg;
    logic signed [40:0]       off_s7_reg;
    logic signed [TEMP_W-1:0] temp_s7_reg;

    assign pp_lo_next = {20'b0, d1_s6_reg} * {24'b0, sens_s6_reg[19:0]};
    assign pp_hi_next = $signed({1'b0, d1_s6_reg}) * $signed(sens_s6_reg[40:20]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_lo_s7_reg <= pp_lo_next;
            pp_hi_s7_reg <= pp_hi_next;
            off_s7_reg   <= off_s6_reg;
            temp_s7_reg  <= temp_s6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: partial product sum
    // ------------------------------------------------------------------
    logic signed [65:0]       prod_next;
    logic signed [65:0]       prod_s8_reg;
    logic signed [40:0]       off_s8_reg;
    logic signed [TEMP_W-1:0] temp_s8_reg;

    assign prod_next = $signed({pp_hi_s7_reg, 20'b0}) + $signed({22'b0, pp_lo_s7_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_s8_reg <= prod_next;
            off_s8_reg  <= off_s7_reg;
            temp_s8_reg <= temp_s7_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: pressure, output register
    // ------------------------------------------------------------------
    logic signed [45:0]        px_next;
    logic signed [PRESS_W-1:0] press_out_reg;
    logic signed [TEMP_W-1:0]  temp_out_reg;

    // |D1*SENS| < 2^62, so the final value fits in 31 bits and the 32-bit
    // saturation reduces to a sign extension.
    assign px_next = $signed(prod_s8_reg[65:21]) - $signed({{4{off_s8_reg[40]}}, off_s8_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            press_out_reg <= {px_next[45], px_next[45:15]};
            temp_out_reg  <= temp_s8_reg;
        end
    end

    assign m_axis_tdata = {5'b0, temp_out_reg, press_out_reg};

endmodule

### bench/tb_baro_pressure_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric pressure compensation testbench
// Feeds raw D1/D2 pairs through the stream input under a series of coefficient
// banks, predicts each compensated reading, and checks every result in order.
// A short directed table comes first, then random requests in several phases.
// ----------------------------------------------------------------------------
module tb_baro_pressure_compensation_top;

    import baro_pkg::*;

    // Bench timing and load
    localparam int  IDLE_PCT     = 21;       // percent of cycles each side idles
    localparam int  PHASE_ITEMS  = 116;      // random requests per coefficient bank
    localparam int  CALM_PHASE   = 3;        // phase run with no idling at all
    localparam int  HOLD_PHASE   = 1;        // phase where the sender drains mid-way
    localparam int  CYCLE_LIMIT  = 100000;
    localparam int  NUM_DIRECTED = 22;

    localparam logic [RAW_W-1:0]  RAW_MAX  = {RAW_W{1'b1}};
    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

    // Indexes past the last coefficient; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Saturation limits of the pressure output
    localparam longint PRESS_MAX = 64'sd2147483647;
    localparam longint PRESS_MIN = -64'sd2147483648;

    // C1..C6, indexed by register index
    typedef logic [REG_TEMPSENS:0][COEF_W-1:0] coef_bank_t;

    typedef struct packed {
        logic signed [PRESS_W-1:0] pressure;
        logic signed [TEMP_W-1:0]  temp;
    } reading_t;

    typedef enum {
        SET_RESET,      // all zero, as after reset
        SET_OFF_ONLY,   // C2 at max, rest zero: pure offset
        SET_TYPICAL,    // factory-like values
        SET_ALL_MAX,
        SET_MIX_A,
        SET_MIX_B,
        SET_RANDOM
    } coef_set_t;

    typedef struct {
        coef_set_t        cset;
        logic [RAW_W-1:0] d1;
        logic [RAW_W-1:0] d2;
        bit               known;   // expected reading typed in below
        int               exp_p;
        int               exp_t;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Directed table. Typed-in rows are the ones that read off directly:
    // zero coefficients give 0 Pa at 20.00 C, offset-only gives -C2*2^16/2^15.
    // The typical bank walks the second-order thresholds: exactly 20.00 C,
    // 19.99 C, exactly -15.00 C, -15.01 C, plus the deep-cold corner.
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{SET_RESET,    24'h000000, 24'h000000, 1'b1, 0,       2000},
        '{SET_RESET,    24'hFFFFFF, 24'hFFFFFF, 1'b1, 0,       2000},
        '{SET_RESET,    24'hAAAAAA, 24'h555555, 1'b1, 0,       2000},
        '{SET_OFF_ONLY, 24'hFFFFFF, 24'h000000, 1'b1, -131070, 2000},
        '{SET_OFF_ONLY, 24'h000000, 24'hFFFFFF, 1'b1, -131070, 2000},
        '{SET_TYPICAL,  24'd9085466, 24'd8569150, 1'b0, 0, 0},   // warm, first order
        '{SET_TYPICAL,  24'd9085466, 24'd8566784, 1'b0, 0, 0},   // dT = 0, 20.00 C
        '{SET_TYPICAL,  24'd9085466, 24'd8566783, 1'b0, 0, 0},   // 19.99 C
        '{SET_TYPICAL,  24'd9085466, 24'd7529764, 1'b0, 0, 0},   // -15.00 C
        '{SET_TYPICAL,  24'd9085466, 24'd7529763, 1'b0, 0, 0},   // -15.01 C
        '{SET_TYPICAL,  24'hFFFFFF, 24'h000000, 1'b0, 0, 0},     // coldest
        '{SET_TYPICAL,  24'hFFFFFF, 24'hFFFFFF, 1'b0, 0, 0},     // hottest
        '{SET_TYPICAL,  24'h000000, 24'd8000000, 1'b0, 0, 0},
        '{SET_TYPICAL,  24'hFFFFFF, 24'd8000000, 1'b0, 0, 0},
        '{SET_ALL_MAX,  24'hFFFFFF, 24'h000000, 1'b0, 0, 0},
        '{SET_ALL_MAX,  24'hFFFFFF, 24'hFFFFFF, 1'b0, 0, 0},
        '{SET_ALL_MAX,  24'h000000, 24'h000000, 1'b0, 0, 0},
        '{SET_ALL_MAX,  24'h000001, 24'hFFFF00, 1'b0, 0, 0},     // dT = 0
        '{SET_MIX_A,    24'hFFFFFF, 24'h000000, 1'b0, 0, 0},
        '{SET_MIX_A,    24'hFFFFFF, 24'hFFFFFF, 1'b0, 0, 0},
        '{SET_MIX_B,    24'hFFFFFF, 24'h000000, 1'b0, 0, 0},
        '{SET_MIX_B,    24'h123456, 24'hFFFFFF, 1'b0, 0, 0}
    };

    // Coefficient banks for the random phases
    coef_set_t phase_plan [8] = '{
        SET_TYPICAL, SET_RANDOM, SET_ALL_MAX, SET_RANDOM,
        SET_MIX_A,   SET_RANDOM, SET_RESET,   SET_MIX_B
    };

    // DUT ports; every input known from time zero
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [COEF_W-1:0]     cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Bench state
    coef_bank_t coef_q = '0;          // bench copy of C1..C6
    reading_t   awaited_readings[$];  // predicted readings, oldest first
    int         fault_count = 0;
    int         cycle_count = 0;
    bit         calm = 1'b0;          // suppress idling on both sides

    baro_pressure_compensation_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Compensation predictor. 64-bit signed throughout; >>> on a signed
    // longint floors, matching the power-of-two divisions of the formulas.
    // ------------------------------------------------------------------------
    function automatic reading_t compensate_reading(input coef_bank_t c,
                                                    input logic [RAW_W-1:0] d1_raw,
                                                    input logic [RAW_W-1:0] d2_raw);
        longint   c1, c2, c3, c4, c5, c6, d1, d2;
        longint   t_ref, t_low;
        longint   dt, temp, off, sens, p;
        longint   t2, sq, off2, sens2;
        reading_t r;
        c1    = longint'(c[REG_SENS]);
        c2    = longint'(c[REG_OFF]);
        c3    = longint'(c[REG_TCS]);
        c4    = longint'(c[REG_TCO]);
        c5    = longint'(c[REG_TREF]);
        c6    = longint'(c[REG_TEMPSENS]);
        d1    = longint'(d1_raw);
        d2    = longint'(d2_raw);
        t_ref = longint'(TEMP_REF);
        t_low = longint'(TEMP_LOW);

        // first order
        dt   = d2 - c5 * 256;
        temp = t_ref + ((dt * c6) >>> 23);
        off  = c2 * 65536 + ((c4 * dt) >>> 7);
        sens = c1 * 32768 + ((c3 * dt) >>> 8);

        // second order below 20.00 C, extra term below -15.00 C
        if (temp < t_ref)
        begin
            t2    = (dt * dt) >>> 31;
            sq    = (temp - t_ref) * (temp - t_ref);
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (temp < t_low)
            begin
                sq    = (temp - t_low) * (temp - t_low);
                off2  = off2 + 7 * sq;
                sens2 = sens2 + ((11 * sq) >>> 1);
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
        end

        p = (((d1 * sens) >>> 21) - off) >>> 15;
        if (p > PRESS_MAX) p = PRESS_MAX;
        if (p < PRESS_MIN) p = PRESS_MIN;
        if (temp > longint'(TEMP_MAX)) temp = longint'(TEMP_MAX);
        if (temp < longint'(TEMP_MIN)) temp = longint'(TEMP_MIN);

        r.pressure = p[PRESS_W-1:0];
        r.temp     = temp[TEMP_W-1:0];
        return r;
    endfunction

    // Random coefficient, biased toward the ends of the range
    function automatic logic [COEF_W-1:0] pick_coef();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return COEF_MAX;
        return COEF_W'($urandom_range(int'(COEF_MAX)));
    endfunction

    function automatic coef_bank_t bank_of(input coef_set_t s);
        coef_bank_t b;
        b = '0;
        case (s)
            SET_OFF_ONLY: b[REG_OFF] = COEF_MAX;
            SET_TYPICAL:
            begin
                b[REG_SENS]     = 16'd40127;
                b[REG_OFF]      = 16'd36924;
                b[REG_TCS]      = 16'd23317;
                b[REG_TCO]      = 16'd23282;
                b[REG_TREF]     = 16'd33464;
                b[REG_TEMPSENS] = 16'd28312;
            end
            SET_ALL_MAX: b = '1;
            SET_MIX_A:
            begin
                b[REG_SENS]     = COEF_MAX;
                b[REG_TCS]      = COEF_MAX;
                b[REG_TEMPSENS] = COEF_MAX;
            end
            SET_MIX_B:
            begin
                b[REG_OFF]      = COEF_MAX;
                b[REG_TCO]      = COEF_MAX;
                b[REG_TREF]     = COEF_MAX;
                b[REG_TEMPSENS] = 16'd1;
            end
            SET_RANDOM:
                for (int i = int'(REG_SENS); i <= int'(REG_TEMPSENS); i++)
                    b[i] = pick_coef();
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw_pressure();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 10)
            return RAW_MAX;
        return RAW_W'($urandom_range(int'(RAW_MAX)));
    endfunction

    // Raw temperature: full range, or clustered around C5*256 so the
    // threshold regions get exercised under every bank
    function automatic logic [RAW_W-1:0] pick_raw_temperature();
        longint center, v;
        int     r;
        center = longint'(coef_q[REG_TREF]) * 256;
        r      = $urandom_range(99);
        if (r < 40)
            v = longint'($urandom_range(int'(RAW_MAX)));
        else if (r < 80)
            v = center + longint'($urandom_range(1 << 21)) - (1 << 20);
        else if (r < 95)
            v = center + longint'($urandom_range(8192)) - 4096;
        else
            v = $urandom_range(1) ? longint'(RAW_MAX) : 0;
        if (v < 0)
            v = 0;
        if (v > longint'(RAW_MAX))
            v = longint'(RAW_MAX);
        return v[RAW_W-1:0];
    endfunction

    // One request on the input stream; the prediction is queued on acceptance.
    // Valid stays high straight into the next request when no gap is drawn.
    task automatic send_request(input logic [RAW_W-1:0] d1,
                                input logic [RAW_W-1:0] d2,
                                input reading_t         want);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d2, d1};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        awaited_readings.push_back(want);
    endtask

    // Stop sending and wait for every predicted reading to come back
    task automatic drain_readings();
        s_axis_tvalid <= 1'b0;
        while (awaited_readings.size() != 0)
            @(posedge clk);
    endtask

    // Write C1..C6, then the two spare indexes, which the block must drop
    task automatic load_coefs(input coef_bank_t bank);
        drain_readings();
        repeat (NUM_STAGES + 2) @(posedge clk);
        for (int i = int'(REG_SENS); i <= int'(REG_SPARE_HI); i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= (i <= int'(REG_TEMPSENS)) ? bank[i] : pick_coef();
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        coef_q = bank;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, in-order field compare
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        reading_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_readings.size() == 0)
                begin
                    $error("unexpected result: tdata %h", m_axis_tdata);
                    fault_count++;
                end
                else
                begin
                    want = awaited_readings.pop_front();
                    if (m_axis_tdata[PRESS_W-1:0] !== want.pressure)
                    begin
                        $error("pressure_pa: expected %0d, got %0d", want.pressure,
                               $signed(m_axis_tdata[PRESS_W-1:0]));
                        fault_count++;
                    end
                    if (m_axis_tdata[PRESS_W+TEMP_W-1:PRESS_W] !== want.temp)
                    begin
                        $error("temp_centideg: expected %0d, got %0d", want.temp,
                               $signed(m_axis_tdata[PRESS_W+TEMP_W-1:PRESS_W]));
                        fault_count++;
                    end
                    if (m_axis_tdata[OUT_DATA_W-1:PRESS_W+TEMP_W] !== '0)
                    begin
                        $error("padding: expected 0, got %h",
                               m_axis_tdata[OUT_DATA_W-1:PRESS_W+TEMP_W]);
                        fault_count++;
                    end
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        coef_set_t        active_set;
        logic [RAW_W-1:0] d1, d2;
        reading_t         want;

        active_set = SET_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; a bank change waits for the pipeline to empty
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cset != active_set)
            begin
                load_coefs(bank_of(directed_rows[i].cset));
                active_set = directed_rows[i].cset;
            end
            if (directed_rows[i].known)
            begin
                want.pressure = directed_rows[i].exp_p;
                want.temp     = directed_rows[i].exp_t[TEMP_W-1:0];
            end
            else
                want = compensate_reading(coef_q, directed_rows[i].d1, directed_rows[i].d2);
            send_request(directed_rows[i].d1, directed_rows[i].d2, want);
        end

        // Random phases, one coefficient bank each
        foreach (phase_plan[ph])
        begin
            load_coefs(bank_of(phase_plan[ph]));
            calm = (ph == CALM_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender holds off until the result side has caught up
                if (ph == HOLD_PHASE && n == PHASE_ITEMS / 2)
                    drain_readings();
                d1   = pick_raw_pressure();
                d2   = pick_raw_temperature();
                want = compensate_reading(coef_q, d1, d2);
                send_request(d1, d2, want);
            end
        end
        calm = 1'b0;

        // Let the pipeline empty, then a few more cycles for stray results
        drain_readings();
        repeat (NUM_STAGES + 4) @(posedge clk);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
